### design/rhc_pkg.sv
package rhc_pkg;

	localparam int CHANNEL_BITS_DEF = 8;

	localparam int IN_BITS  = 8;
	localparam int HUE_BITS = 13;
	localparam int SAT_BITS = 13;
	localparam int VAL_BITS = 8;

	// quotient bits of both divisions: saturation reaches 4096, hue offset 960
	localparam int QUO_BITS  = 13;
	localparam int SAT_SHIFT = 12;

	localparam int SECTOR_UNITS = 60 * 16;

	localparam logic [HUE_BITS-1:0] GREEN_BASE = HUE_BITS'(120 * 16);
	localparam logic [HUE_BITS-1:0] BLUE_BASE  = HUE_BITS'(240 * 16);
	localparam logic [HUE_BITS-1:0] FULL_TURN  = HUE_BITS'(360 * 16);

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_RED_WRAP,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	typedef struct packed {
		logic [IN_BITS-1:0] red_in;
		logic [IN_BITS-1:0] green_in;
		logic [IN_BITS-1:0] blue_in;
	} pix_word_t;

	typedef struct packed {
		logic [HUE_BITS-1:0] hue_out;
		logic [SAT_BITS-1:0] sat_out;
		logic [VAL_BITS-1:0] value_out;
	} hsv_word_t;

	typedef struct packed {
		logic                neg;
		sector_t             sector;
		logic [VAL_BITS-1:0] value;
	} hue_tag_t;

	function automatic logic [HUE_BITS-1:0] sector_base(input sector_t s);
		logic [HUE_BITS-1:0] base;
		case (s)
			SEC_RED:      base = '0;
			SEC_RED_WRAP: base = FULL_TURN;
			SEC_GREEN:    base = GREEN_BASE;
			SEC_BLUE:     base = BLUE_BASE;
			default:      base = '0;
		endcase
		return base;
	endfunction

endpackage

### design/rhc_front.sv
module rhc_front #(
	parameter int CHANNEL_BITS = rhc_pkg::CHANNEL_BITS_DEF,
	localparam int NUM_W = CHANNEL_BITS + rhc_pkg::QUO_BITS
) (
	input  logic                    clk,
	input  logic [1:0]              en,
	input  rhc_pkg::pix_word_t      pix,
	output logic [NUM_W-1:0]        hue_num,
	output logic [CHANNEL_BITS-1:0] hue_den,
	output rhc_pkg::hue_tag_t       hue_tag,
	output logic [NUM_W-1:0]        sat_num,
	output logic [CHANNEL_BITS-1:0] sat_den,
	output logic                    zero_d
);

	localparam int IN_LOW  = (CHANNEL_BITS < rhc_pkg::IN_BITS) ? CHANNEL_BITS : rhc_pkg::IN_BITS;
	localparam int VAL_LOW = (CHANNEL_BITS < rhc_pkg::VAL_BITS) ? CHANNEL_BITS :
		rhc_pkg::VAL_BITS;

	logic [CHANNEL_BITS-1:0]      r, g, b, mx, mn, opa, opb;
	logic [rhc_pkg::VAL_BITS-1:0] val;
	rhc_pkg::sector_t             sec;

	logic [CHANNEL_BITS-1:0]      opa_s1, opb_s1, d_s1, mx_s1;
	logic [rhc_pkg::VAL_BITS-1:0] val_s1;
	rhc_pkg::sector_t             sec_s1;
	logic                         zero_s1;

	logic [CHANNEL_BITS-1:0]      diff;
	logic                         neg;

	logic [NUM_W-1:0]             hue_num_s2, sat_num_s2;
	logic [CHANNEL_BITS-1:0]      hue_den_s2, sat_den_s2;
	rhc_pkg::hue_tag_t            tag_s2;
	logic                         zero_s2;

	// stage 1: channel mask, max, min and sector
	always_comb begin
		r = '0;
		g = '0;
		b = '0;
		r[IN_LOW-1:0] = pix.red_in[IN_LOW-1:0];
		g[IN_LOW-1:0] = pix.green_in[IN_LOW-1:0];
		b[IN_LOW-1:0] = pix.blue_in[IN_LOW-1:0];
		mx = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		mn = r;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		val = '0;
		val[VAL_LOW-1:0] = mx[VAL_LOW-1:0];
		if (mx == b) begin
			sec = rhc_pkg::SEC_BLUE;
			opa = r;
			opb = g;
		end else if (mx == g) begin
			sec = rhc_pkg::SEC_GREEN;
			opa = b;
			opb = r;
		end else if (g >= b) begin
			sec = rhc_pkg::SEC_RED;
			opa = g;
			opb = b;
		end else begin
			sec = rhc_pkg::SEC_RED_WRAP;
			opa = g;
			opb = b;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			opa_s1  <= opa;
			opb_s1  <= opb;
			d_s1    <= mx - mn;
			mx_s1   <= mx;
			val_s1  <= val;
			sec_s1  <= sec;
			zero_s1 <= (mx == mn);
		end
	end

	// stage 2: dividends and divisors
	always_comb begin
		neg  = opa_s1 < opb_s1;
		diff = neg ? (opb_s1 - opa_s1) : (opa_s1 - opb_s1);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			hue_num_s2    <= NUM_W'(diff) * NUM_W'(rhc_pkg::SECTOR_UNITS);
			hue_den_s2    <= d_s1;
			sat_num_s2    <= NUM_W'(d_s1) << rhc_pkg::SAT_SHIFT;
			sat_den_s2    <= mx_s1;
			tag_s2.neg    <= neg;
			tag_s2.sector <= sec_s1;
			tag_s2.value  <= val_s1;
			zero_s2       <= zero_s1;
		end
	end

	assign hue_num = hue_num_s2;
	assign hue_den = hue_den_s2;
	assign hue_tag = tag_s2;
	assign sat_num = sat_num_s2;
	assign sat_den = sat_den_s2;
	assign zero_d  = zero_s2;

endmodule

### design/rhc_divider.sv
module rhc_divider #(
	parameter int NUM_W = 21,
	parameter int DEN_W = 8,
	parameter int QUO_W = 13,
	parameter int TAG_W = 1
) (
	input  logic             clk,
	input  logic [QUO_W-1:0] en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [TAG_W-1:0] tag_i,
	output logic [QUO_W-1:0] quo,
	output logic [NUM_W-1:0] rem,
	output logic [TAG_W-1:0] tag_o
);

	logic [NUM_W-1:0] rem_s [QUO_W];
	logic [QUO_W-1:0] quo_s [QUO_W];
	logic [DEN_W-1:0] den_s [QUO_W];
	logic [TAG_W-1:0] tag_s [QUO_W];

	// restoring division, one quotient bit per stage, msb first
	for (genvar j = 0; j < QUO_W; j++) begin : g_stage
		localparam int SH = QUO_W - 1 - j;

		logic [NUM_W-1:0] rem_in, trial;
		logic [QUO_W-1:0] quo_in;
		logic [DEN_W-1:0] den_in;
		logic [TAG_W-1:0] tag_in;
		logic             fits;

		if (j == 0) begin : g_first
			assign rem_in = num;
			assign quo_in = '0;
			assign den_in = den;
			assign tag_in = tag_i;
		end else begin : g_next
			assign rem_in = rem_s[j-1];
			assign quo_in = quo_s[j-1];
			assign den_in = den_s[j-1];
			assign tag_in = tag_s[j-1];
		end

		assign trial = NUM_W'(den_in) << SH;
		assign fits  = rem_in >= trial;

		always_ff @(posedge clk) begin
			if (en[j]) begin
				rem_s[j] <= fits ? (rem_in - trial) : rem_in;
				quo_s[j] <= {quo_in[QUO_W-2:0], fits};
				den_s[j] <= den_in;
				tag_s[j] <= tag_in;
			end
		end
	end

	assign quo   = quo_s[QUO_W-1];
	assign rem   = rem_s[QUO_W-1];
	assign tag_o = tag_s[QUO_W-1];

endmodule

### design/rhc_back.sv
module rhc_back #(
	parameter int CHANNEL_BITS = rhc_pkg::CHANNEL_BITS_DEF,
	localparam int NUM_W = CHANNEL_BITS + rhc_pkg::QUO_BITS
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic [rhc_pkg::QUO_BITS-1:0] hue_quo,
	input  logic [NUM_W-1:0]             hue_rem,
	input  rhc_pkg::hue_tag_t            hue_tag,
	input  logic [rhc_pkg::QUO_BITS-1:0] sat_quo,
	input  logic                         zero_d,
	output rhc_pkg::hsv_word_t           hsv
);

	logic [rhc_pkg::HUE_BITS-1:0] base, ofs, hue;
	rhc_pkg::hsv_word_t           hsv_s16;

	// negative offsets round away from the sector base, so the quotient rounds up
	always_comb begin
		base = rhc_pkg::sector_base(hue_tag.sector);
		ofs  = rhc_pkg::HUE_BITS'(hue_quo);
		if (zero_d) begin
			hue = '0;
		end else if (hue_tag.neg) begin
			hue = base - ofs - rhc_pkg::HUE_BITS'(hue_rem != '0);
		end else begin
			hue = base + ofs;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hsv_s16.hue_out   <= hue;
			hsv_s16.sat_out   <= zero_d ? '0 : rhc_pkg::SAT_BITS'(sat_quo);
			hsv_s16.value_out <= hue_tag.value;
		end
	end

	assign hsv = hsv_s16;

endmodule

### design/rgb_to_hsv_converter_core.sv
// channel | direction | handshake             | word
// pix     | in        | pix_valid / pix_ready | red_in, green_in, blue_in
// hsv     | out       | hsv_valid / hsv_ready | hue_out, sat_out, value_out
//
// one pixel per clock sustained while hsv_ready is high; the pipeline is the 13-stage
// restoring divider (one quotient bit per stage) plus two front stages and
// the output stage
// reset clears only the per-stage valid bits
// a stalled output holds its word; empty stages still fill behind it, so
// pix_ready stays high until every stage holds a word
module rgb_to_hsv_converter_core #(
	parameter int CHANNEL_BITS = rhc_pkg::CHANNEL_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pix_valid,
	output logic               pix_ready,
	input  rhc_pkg::pix_word_t pix,
	output logic               hsv_valid,
	input  logic               hsv_ready,
	output rhc_pkg::hsv_word_t hsv
);

	localparam int NUM_W  = CHANNEL_BITS + rhc_pkg::QUO_BITS;
	localparam int STAGES = rhc_pkg::QUO_BITS + 3;
	localparam int TAG_W  = $bits(rhc_pkg::hue_tag_t);

	logic [STAGES-1:0] vld_q, load;

	logic [NUM_W-1:0]             hue_num, sat_num, hue_rem;
	logic [CHANNEL_BITS-1:0]      hue_den, sat_den;
	rhc_pkg::hue_tag_t            hue_tag_f, hue_tag_d;
	logic                         zero_f, zero_d;
	logic [TAG_W-1:0]             hue_tag_bits;
	logic [rhc_pkg::QUO_BITS-1:0] hue_quo, sat_quo;

	// a stage loads when it is empty or its word moves on
	always_comb begin
		load[STAGES-1] = !vld_q[STAGES-1] || hsv_ready;
		for (int k = STAGES - 2; k >= 0; k--) begin
			load[k] = !vld_q[k] || load[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (load[0]) vld_q[0] <= pix_valid;
			for (int k = 1; k < STAGES; k++) begin
				if (load[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign pix_ready = load[0];
	assign hsv_valid = vld_q[STAGES-1];

	rhc_front #(
		.CHANNEL_BITS(CHANNEL_BITS)
	) u_front (
		.clk     (clk),
		.en      (load[1:0]),
		.pix     (pix),
		.hue_num (hue_num),
		.hue_den (hue_den),
		.hue_tag (hue_tag_f),
		.sat_num (sat_num),
		.sat_den (sat_den),
		.zero_d  (zero_f)
	);

	rhc_divider #(
		.NUM_W (NUM_W),
		.DEN_W (CHANNEL_BITS),
		.QUO_W (rhc_pkg::QUO_BITS),
		.TAG_W (TAG_W)
	) u_hue_div (
		.clk   (clk),
		.en    (load[2 +: rhc_pkg::QUO_BITS]),
		.num   (hue_num),
		.den   (hue_den),
		.tag_i (hue_tag_f),
		.quo   (hue_quo),
		.rem   (hue_rem),
		.tag_o (hue_tag_bits)
	);

	assign hue_tag_d = rhc_pkg::hue_tag_t'(hue_tag_bits);

	rhc_divider #(
		.NUM_W (NUM_W),
		.DEN_W (CHANNEL_BITS),
		.QUO_W (rhc_pkg::QUO_BITS),
		.TAG_W (1)
	) u_sat_div (
		.clk   (clk),
		.en    (load[2 +: rhc_pkg::QUO_BITS]),
		.num   (sat_num),
		.den   (sat_den),
		.tag_i (zero_f),
		.quo   (sat_quo),
		.rem   (),
		.tag_o (zero_d)
	);

	rhc_back #(
		.CHANNEL_BITS(CHANNEL_BITS)
	) u_back (
		.clk     (clk),
		.en      (load[STAGES-1]),
		.hue_quo (hue_quo),
		.hue_rem (hue_rem),
		.hue_tag (hue_tag_d),
		.sat_quo (sat_quo),
		.zero_d  (zero_d),
		.hsv     (hsv)
	);

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid |-> (hsv.hue_out < rhc_pkg::FULL_TURN))
		else $error("hue out of range");

	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid |-> (hsv.sat_out <= rhc_pkg::SAT_BITS'(1 << rhc_pkg::SAT_SHIFT)))
		else $error("saturation out of range");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_ready |-> (hsv_valid && !hsv_ready && (&vld_q)))
		else $error("input blocked while pipeline has room");

endmodule
